FILE: hw/rtl/tcce_pkg.sv
// tcce_pkg: state type, opcodes and character constants for the text console cursor engine.
// No dependencies; imported by text_console_cursor_engine.
package tcce_pkg;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_EXEC,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_READ_WAIT,
        ST_PUT,
        ST_DONE
    } t_state;

    localparam logic [1:0]  OP_PUT       = 2'd0;
    localparam logic [1:0]  OP_CLEAR     = 2'd1;
    localparam logic [1:0]  OP_ATTR      = 2'd2;
    localparam logic [1:0]  OP_READ      = 2'd3;

    localparam logic        CFG_FG       = 1'b0;
    localparam logic        CFG_BG       = 1'b1;

    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CH_BACKSPACE = 8'h7F;
    localparam logic [7:0]  CH_BLANK     = 8'h20;

    localparam logic [15:0] RESET_CELL   = 16'h0720;
    localparam logic [3:0]  FG_RESET     = 4'd7;
    localparam logic [3:0]  BG_RESET     = 4'd0;

endpackage

FILE: hw/rtl/text_console_cursor_engine.sv
// text_console_cursor_engine: cursor tracking and screen cell store of a text console.
// Depends on tcce_pkg (state type, opcodes, character constants).
//
// A ROWS x COLS screen of 16-bit cells (attribute in 15..8, character in 7..0) sits in one
// single-port-write, registered-read memory, and a small sequencer walks it. Every request
// returns exactly one result. A plain character passes through EXEC and PUT to DONE; a
// backspace, a zero byte or a newline above the bottom row goes from EXEC straight to
// DONE; a read passes through READ_WAIT (not when the index is off the screen). From DONE
// the sequencer goes back to IDLE before the next request is taken. A newline on the
// bottom row, or a character that wraps off the bottom row, scrolls: the rows are copied
// up through the source-address adder (COPY_RD reads, COPY_WR writes), then FILL blanks
// the last row. Clear writes N cells at one a cycle, with N = ROWS*COLS; apply-attribute
// does a read-modify-write on every cell. After reset the block fills the store with
// blank light-gray cells and stalls requests meanwhile; configuration writes are taken at
// any time. The result waits in an output register, so the next request is accepted while
// the previous result is still stalled.
module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_cursor_pos,
    output logic        o_cursor_moved,
    output logic        o_scrolled,
    output logic [15:0] o_cell_data
);

    localparam int NCELLS    = COLS * ROWS;
    localparam int AW        = $clog2(NCELLS);
    localparam int LW        = $clog2(NCELLS + 1);
    localparam int CW        = $clog2(COLS + 1);
    localparam int RW        = $clog2(ROWS);
    localparam int CELL_LAST = NCELLS - 1;
    localparam int SCR_LAST  = NCELLS - COLS - 1;
    localparam int BOT_BASE  = (ROWS - 1) * COLS;

    // screen store
    logic [15:0] r_mem [NCELLS];
    logic [15:0] r_rdata;

    t_state r_state, n_state;

    // cursor: column may sit at COLS after the last column is written; r_lin mirrors
    // row*COLS+col so no multiply is ever needed
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [LW-1:0] r_lin;

    logic [3:0]    r_fg, r_bg;
    logic [AW-1:0] r_addr;

    // request being worked on
    logic [1:0]    r_op;
    logic [7:0]    r_ch;
    logic [10:0]   r_idx;
    logic          r_item;      // 0 while the reset fill runs
    logic          r_or_mode;   // copy loop applies attribute instead of scrolling
    logic          r_pend_put;  // character still to write after a scroll
    logic          r_moved, r_sc;
    logic [15:0]   r_data;

    logic          r_out_valid;
    logic [10:0]   r_o_pos;
    logic          r_o_moved, r_o_sc;
    logic [15:0]   r_o_data;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [15:0]   w_wdata;
    logic [15:0]   w_attr, w_blank;
    logic          w_in_acc, w_out_free;
    logic          w_bottom, w_at_edge, w_bs_ok, w_idx_ok, w_addr_last;
    logic [AW-1:0] w_addr_src;
    logic [31:0]   w_pos_wide;

    assign w_attr      = {r_bg, r_fg, 8'h00};
    assign w_blank     = w_attr | {8'h00, CH_BLANK};
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_bottom    = 32'(r_row) >= ROWS - 1;
    assign w_at_edge   = 32'(r_col) >= COLS;
    assign w_bs_ok     = (r_col != '0) || (r_row != '0);
    assign w_idx_ok    = 32'(r_idx) < NCELLS;
    // address unit: source offset for the scroll copy
    assign w_addr_src  = AW'(32'(r_addr) + COLS);
    assign w_addr_last = r_or_mode ? (r_addr == AW'(CELL_LAST)) : (r_addr == AW'(SCR_LAST));
    assign w_pos_wide  = 32'(r_lin);

    // ------------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (r_addr == AW'(CELL_LAST)) begin
                    if (!r_item) begin
                        n_state = ST_IDLE;
                    end else if (r_pend_put) begin
                        n_state = ST_PUT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_op)
                    OP_PUT: begin
                        if (r_ch == CH_BACKSPACE || r_ch == CH_NUL) begin
                            n_state = ST_DONE;
                        end else if (r_ch == CH_NEWLINE) begin
                            n_state = w_bottom ? ST_COPY_RD : ST_DONE;
                        end else begin
                            n_state = (w_at_edge && w_bottom) ? ST_COPY_RD : ST_PUT;
                        end
                    end
                    OP_CLEAR: n_state = ST_FILL;
                    OP_ATTR:  n_state = ST_COPY_RD;
                    OP_READ:  n_state = w_idx_ok ? ST_READ_WAIT : ST_DONE;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_COPY_RD: n_state = ST_COPY_WR;
            ST_COPY_WR: begin
                if (w_addr_last) begin
                    n_state = r_or_mode ? ST_DONE : ST_FILL;
                end else begin
                    n_state = ST_COPY_RD;
                end
            end
            ST_READ_WAIT: n_state = ST_DONE;
            ST_PUT:       n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------ outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_we       = 1'b0;
        w_waddr    = r_addr;
        w_wdata    = w_blank;
        w_raddr    = r_addr;
        unique case (r_state)
            ST_FILL: begin
                w_we    = 1'b1;
                w_wdata = r_item ? w_blank : RESET_CELL;
            end
            ST_EXEC: begin
                if (r_op == OP_PUT && r_ch == CH_BACKSPACE && w_bs_ok) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_lin - LW'(1));
                end
                w_raddr = AW'(r_idx);
            end
            ST_COPY_RD: begin
                w_raddr = r_or_mode ? r_addr : w_addr_src;
            end
            ST_COPY_WR: begin
                w_we    = 1'b1;
                w_wdata = r_or_mode ? (r_rdata | w_attr) : r_rdata;
            end
            ST_PUT: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_lin);
                w_wdata = w_attr | {8'h00, r_ch};
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------ store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // ------------------------------------------------------------------ control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_addr      <= '0;
            r_item      <= 1'b0;
            r_pend_put  <= 1'b0;
            r_or_mode   <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_lin       <= '0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FG:  r_fg <= i_cfg_data;
                    CFG_BG:  r_bg <= i_cfg_data;
                    default: ;
                endcase
            end

            // result register: loaded from DONE, emptied when taken
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_FILL: begin
                    r_addr <= AW'(32'(r_addr) + 1);
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_item     <= 1'b1;
                        r_pend_put <= 1'b0;
                        r_or_mode  <= (i_opcode == OP_ATTR);
                        r_addr     <= '0;
                    end
                end
                ST_EXEC: begin
                    if (r_op == OP_PUT) begin
                        if (r_ch == CH_BACKSPACE) begin
                            if (w_bs_ok) begin
                                if (r_col == '0) begin
                                    r_row <= RW'(32'(r_row) - 1);
                                    r_col <= CW'(COLS - 1);
                                end else begin
                                    r_col <= CW'(32'(r_col) - 1);
                                end
                                r_lin <= LW'(r_lin - LW'(1));
                            end
                        end else if (r_ch == CH_NEWLINE) begin
                            r_col <= '0;
                            if (w_bottom) begin
                                r_lin <= LW'(BOT_BASE);
                            end else begin
                                r_row <= RW'(32'(r_row) + 1);
                                r_lin <= LW'(32'(r_lin) - 32'(r_col) + COLS);
                            end
                        end else if (r_ch != CH_NUL) begin
                            // wrap first; the linear position already points at the
                            // next row's first cell unless the screen scrolls
                            if (w_at_edge) begin
                                r_col <= '0;
                                if (w_bottom) begin
                                    r_lin      <= LW'(BOT_BASE);
                                    r_pend_put <= 1'b1;
                                end else begin
                                    r_row <= RW'(32'(r_row) + 1);
                                end
                            end
                        end
                    end
                end
                ST_COPY_WR: begin
                    if (w_addr_last && !r_or_mode) begin
                        r_addr <= AW'(BOT_BASE);
                    end else begin
                        r_addr <= AW'(32'(r_addr) + 1);
                    end
                end
                ST_PUT: begin
                    r_col <= CW'(32'(r_col) + 1);
                    r_lin <= LW'(r_lin + LW'(1));
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------ request payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_op    <= i_opcode;
                    r_ch    <= i_char_code;
                    r_idx   <= i_cell_index;
                    r_moved <= 1'b0;
                    r_sc    <= 1'b0;
                    r_data  <= '0;
                end
            end
            ST_EXEC: begin
                if (r_op == OP_PUT) begin
                    if (r_ch == CH_BACKSPACE) begin
                        r_moved <= w_bs_ok;
                    end else if (r_ch == CH_NEWLINE) begin
                        r_moved <= 1'b1;
                        r_sc    <= w_bottom;
                    end else if (r_ch != CH_NUL) begin
                        r_moved <= 1'b1;
                        r_sc    <= w_at_edge && w_bottom;
                    end
                end
            end
            ST_READ_WAIT: begin
                r_data <= r_rdata;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_o_pos   <= w_pos_wide[10:0];
                    r_o_moved <= r_moved;
                    r_o_sc    <= r_sc;
                    r_o_data  <= r_data;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_pos   = r_o_pos;
    assign o_cursor_moved = r_o_moved;
    assign o_scrolled     = r_o_sc;
    assign o_cell_data    = r_o_data;

    // ------------------------------------------------------------------ checks
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) <= COLS)
        else $error("cursor column beyond right edge");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) <= ROWS - 1)
        else $error("cursor row beyond bottom row");

    a_lin_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_lin) == 32'(r_row) * COLS + 32'(r_col))
        else $error("linear cursor out of step with row and column");

    a_scroll_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_sc |-> r_o_moved)
        else $error("scroll reported without cursor update");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == ST_EXEC)
        else $error("accepted request did not start execution");

endmodule

FILE: test/tb.sv
// tb: self-checking testbench for text_console_cursor_engine.
// Depends on tcce_pkg (opcodes, register indexes, character codes) and the engine RTL.
// A shadow screen predicts each cursor report; random valid/stall traffic on both sides.
module tb;
    import tcce_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int NCELLS = COLS * ROWS;
    // The limit covers the longest single request, apply-attribute, the fill after
    // reset and the receiver hold-off, several times over.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [10:0] pos;
        logic        moved;
        logic        scrolled;
        logic [15:0] data;
    } t_cursor_report;

    // Shadow copy of the screen, cursor and colors; queues the cursor report
    // each accepted request should produce and checks reports in order.
    class console_shadow;
        logic [15:0]    screen [NCELLS];
        logic [6:0]     cur_col;   // may sit at COLS after the last column
        logic [4:0]     cur_row;
        logic [3:0]     fg;
        logic [3:0]     bg;
        t_cursor_report pending[$];
        int unsigned    errors;

        function new();
            foreach (screen[i]) screen[i] = RESET_CELL;
            cur_col = '0;
            cur_row = '0;
            fg = FG_RESET;
            bg = BG_RESET;
            errors = 0;
        endfunction

        function void set_colors(logic [3:0] f, logic [3:0] b);
            fg = f;
            bg = b;
        endfunction

        // Move every row up one and blank the bottom row with the current colors.
        function void scroll_up();
            for (int i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = NCELLS - COLS; i < NCELLS; i++) screen[i] = {bg, fg, CH_BLANK};
        endfunction

        function void take_request(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
            t_cursor_report rep;
            rep = '0;
            case (op)
                OP_PUT: begin
                    if (ch == CH_BACKSPACE) begin
                        // top-left: nothing happens, cursor not rewritten
                        if (cur_col != 0) begin
                            cur_col = cur_col - 1'b1;
                            screen[cur_row * COLS + cur_col] = {bg, fg, CH_BLANK};
                            rep.moved = 1'b1;
                        end else if (cur_row != 0) begin
                            // back over the line start onto the last column above
                            cur_row = cur_row - 1'b1;
                            cur_col = 7'(COLS - 1);
                            screen[cur_row * COLS + cur_col] = {bg, fg, CH_BLANK};
                            rep.moved = 1'b1;
                        end
                    end else if (ch == CH_NEWLINE) begin
                        cur_col = '0;
                        if (cur_row == ROWS - 1) begin
                            scroll_up();
                            rep.scrolled = 1'b1;
                        end else begin
                            cur_row = cur_row + 1'b1;
                        end
                        rep.moved = 1'b1;
                    end else if (ch != CH_NUL) begin
                        // pending wrap resolves only when the next byte lands
                        if (cur_col == COLS) begin
                            cur_col = '0;
                            if (cur_row == ROWS - 1) begin
                                scroll_up();
                                rep.scrolled = 1'b1;
                            end else begin
                                cur_row = cur_row + 1'b1;
                            end
                        end
                        screen[cur_row * COLS + cur_col] = {bg, fg, ch};
                        cur_col = cur_col + 1'b1;
                        rep.moved = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    foreach (screen[i]) screen[i] = {bg, fg, CH_BLANK};
                end
                OP_ATTR: begin
                    foreach (screen[i]) screen[i] = screen[i] | {bg, fg, 8'h00};
                end
                default: begin
                    if (idx < NCELLS) rep.data = screen[idx];
                end
            endcase
            rep.pos = 11'(cur_row * COLS + cur_col);
            pending.push_back(rep);
        endfunction

        function void check_result(logic [10:0] pos, logic moved, logic scrolled,
                                   logic [15:0] data);
            t_cursor_report exp_rep;
            if (pending.size() == 0) begin
                $display("%0t: result with no request outstanding, cursor_pos %0d",
                         $time, pos);
                errors++;
                return;
            end
            exp_rep = pending.pop_front();
            if (pos !== exp_rep.pos) begin
                $display("%0t: cursor_pos expected %0d actual %0d", $time, exp_rep.pos, pos);
                errors++;
            end
            if (moved !== exp_rep.moved) begin
                $display("%0t: cursor_moved expected %0b actual %0b",
                         $time, exp_rep.moved, moved);
                errors++;
            end
            if (scrolled !== exp_rep.scrolled) begin
                $display("%0t: scrolled expected %0b actual %0b",
                         $time, exp_rep.scrolled, scrolled);
                errors++;
            end
            if (data !== exp_rep.data) begin
                $display("%0t: cell_data expected %04h actual %04h",
                         $time, exp_rep.data, data);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_FG;
    logic [3:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode = OP_PUT;
    logic [7:0]  i_char_code = CH_NUL;
    logic [10:0] i_cell_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [10:0] o_cursor_pos;
    logic        o_cursor_moved;
    logic        o_scrolled;
    logic [15:0] o_cell_data;

    console_shadow shadow;
    int unsigned   items_sent = 0;
    int unsigned   reports_seen = 0;
    int unsigned   burst_left = 0;
    int unsigned   quiet_cycles = 0;

    // receiver state
    int unsigned   hold_left = 0;
    int unsigned   next_hold_at = 40;
    int unsigned   stall_mode = 0;
    int unsigned   mode_left = 0;
    logic          beat = 1'b0;

    text_console_cursor_engine #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_char_code    (i_char_code),
        .i_cell_index   (i_cell_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_pos   (o_cursor_pos),
        .o_cursor_moved (o_cursor_moved),
        .o_scrolled     (o_scrolled),
        .o_cell_data    (o_cell_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request; bursts of random length separated by random gaps.
    // Returns after the accepting edge and logs the request in the shadow.
    task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                                input logic [10:0] idx);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 15);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_char_code  <= ch;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.take_request(op, ch, idx);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding report, then let the
    // engine settle back to idle before touching the color registers.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FG;
        i_cfg_data <= fg;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_BG;
        i_cfg_data <= bg;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow.set_colors(fg, bg);
    endtask

    // Mostly text lines, newlines and backspace runs with random bytes, so the
    // cursor reaches the right edge and the bottom row; reads, full-screen ops
    // and raw noise in between.
    task automatic run_random_phase(input int unsigned quota);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned n;
        int unsigned pick;
        logic [7:0]  ch;
        logic [10:0] idx;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                // a line of text, long enough now and then to wrap
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 130)
                                                : $urandom_range(1, 20);
                repeat (n) begin
                    ch = 8'($urandom_range(1, 255));
                    if (ch == CH_NEWLINE || ch == CH_BACKSPACE) ch = CH_BLANK;
                    send_request(OP_PUT, ch, 11'($urandom_range(0, 2047)));
                end
                if ($urandom_range(0, 4) != 0)
                    send_request(OP_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
            end else if (kind < 62) begin
                // backspace runs, occasionally long enough to climb rows
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 100)
                                                : $urandom_range(1, 10);
                repeat (n) send_request(OP_PUT, CH_BACKSPACE, 11'($urandom_range(0, 2047)));
            end else if (kind < 77) begin
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)      idx = 11'($urandom_range(0, NCELLS - 1));
                    else if (pick < 7) idx = 11'($urandom_range(NCELLS - COLS, NCELLS - 1));
                    else if (pick < 8) idx = 11'($urandom_range(0, COLS - 1));
                    else               idx = 11'($urandom_range(NCELLS, 2047));
                    send_request(OP_READ, 8'($urandom_range(0, 255)), idx);
                end
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 30))
                    send_request(OP_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
            end else if (kind < 89) begin
                send_request(OP_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            end else if (kind < 93) begin
                send_request(OP_ATTR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            end else begin
                // raw bytes, zero byte included
                repeat ($urandom_range(1, 3)) begin
                    ch = ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
                    send_request(OP_PUT, ch, 11'($urandom_range(0, 2047)));
                end
            end
        end
    endtask

    // Receiver: the stall pattern switches between random modes. After a
    // set number of reports it holds off for a long stretch so the engine's
    // output register fills and the request side backs up.
    always @(negedge i_clk) begin
        beat = ~beat;
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (reports_seen >= next_hold_at) begin
            hold_left = HOLD_CYCLES - 1;
            next_hold_at += 260;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                2: i_out_stall <= ($urandom_range(0, 9) < 8);
                default: i_out_stall <= beat;
            endcase
        end
    end

    // Report monitor: every accepted report is checked against the oldest
    // prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            shadow.check_result(o_cursor_pos, o_cursor_moved, o_scrolled, o_cell_data);
            reports_seen++;
        end
    end

    // Watchdog: too long with no handshake on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        shadow = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset colors: reset contents, out-of-range read,
        // ignored bytes at top-left, high bytes, line edges.
        send_request(OP_READ, 8'hFF, 11'd0);
        send_request(OP_READ, 8'h00, 11'(NCELLS - 1));
        send_request(OP_READ, 8'h55, 11'h7FF);                // beyond the screen
        send_request(OP_PUT, CH_NUL, 11'h7FF);                // zero byte ignored
        send_request(OP_PUT, CH_BACKSPACE, 11'd0);            // backspace at top-left
        send_request(OP_PUT, 8'hFF, 11'h2AA);
        send_request(OP_PUT, 8'h80, 11'h555);                 // unsigned, no sign fill
        send_request(OP_PUT, 8'h01, 11'd0);
        send_request(OP_READ, 8'h00, 11'd1);
        send_request(OP_PUT, CH_NEWLINE, 11'd0);
        send_request(OP_PUT, CH_BACKSPACE, 11'd0);            // column zero, back a row
        send_request(OP_READ, 8'h00, 11'(COLS - 1));
        send_request(OP_PUT, 8'h41, 11'd0);                   // fills last column
        send_request(OP_PUT, CH_BACKSPACE, 11'd0);            // from the pending-wrap spot
        send_request(OP_PUT, 8'h42, 11'd0);
        send_request(OP_PUT, 8'h43, 11'd0);                   // wraps to the next row
        send_request(OP_READ, 8'h00, 11'(COLS));
        send_request(OP_ATTR, 8'h00, 11'd0);
        send_request(OP_READ, 8'h00, 11'd0);
        send_request(OP_CLEAR, 8'hFF, 11'h7FF);
        send_request(OP_READ, 8'h00, 11'(COLS + 1));
        drain();

        // Random phases, colors changed only while the engine is idle.
        set_colors(4'h0, 4'h0);
        run_random_phase(145);
        drain();
        set_colors(4'hF, 4'hF);
        run_random_phase(145);
        drain();
        set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        run_random_phase(145);
        drain();
        set_colors(4'hF, 4'h0);
        run_random_phase(145);
        drain();

        // catch any stray report after the last expected one
        repeat (30) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
